// ----- hw/rtl/owbm_pkg.sv -----
// Shared types and constants for the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int CFG_W       = 9;
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    localparam logic [CFG_W-1:0] WRITE_RECOVERY_TICKS = 9'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL    = 3'd2,
        CFG_ZERO_LOW      = 3'd3,
        CFG_ONE_LOW       = 3'd4,
        CFG_ONE_HIGH      = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_READ_TAIL     = 3'd7
    } t_cfg_idx;

    typedef logic [NUM_CFG-1:0][CFG_W-1:0] t_cfg_bank;

    // Element i of the packed bank is register i.
    localparam t_cfg_bank CFG_RESET_VALUES = {
        9'd46, 9'd14, 9'd58, 9'd2, 9'd60, 9'd240, 9'd60, 9'd480
    };

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DRV_REL  = 2'd0,
        DRV_LOW  = 2'd1,
        DRV_HIGH = 2'd2
    } t_drive;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W0_LOW   = 4'd4,
        PH_W1_LOW   = 4'd5,
        PH_W1_HIGH  = 4'd6,
        PH_W_REC    = 4'd7,
        PH_R_LOW    = 4'd8,
        PH_R_WAIT   = 4'd9,
        PH_R_TAIL   = 4'd10
    } t_phase;

    // First member sits in the highest bits, so line_drive is bit 0 upward.
    typedef struct packed {
        logic       rejected;
        logic [7:0] rx_byte;
        logic       device_present;
        logic       done_res;
        logic       busy_res;
        t_drive     line_drive;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ----- hw/rtl/one_wire_bus_master.sv -----
// One-wire bus master: tick stream in, per-tick line control and status out.
//
// Usage: every transaction on the slave stream is one microsecond tick. tuser
// carries the command (none, bus reset with presence detect, write byte, read
// byte), tdata the byte to write and the sampled line level. For every tick the
// master stream returns one transaction with the line drive for that tick, the
// busy and done flags, the presence result, the received byte and a reject flag
// for a command given while an operation runs. Bytes go LSB first.
// An accepted tick is held in the input register, processed by the sequencer
// and its result kept in the output register for the master stream. One tick
// per cycle is taken while the master side takes results; the phase timer,
// bit counter and shifter update once per tick, so the stream never throttles
// by itself. The user must write the timing registers through
// i_cfg_we/i_cfg_addr/i_cfg_data only while no operation runs; the block itself
// leaves this unchecked. They reset to the standard bus timings.
// Reset (synchronous, active low) empties both stream registers and returns
// the sequencer to idle. A stalled master side holds its transaction, and the
// slave side keeps taking ticks until the input register is also full.
`timescale 1ns / 1ps

module one_wire_bus_master #(
    parameter int TIMER_WIDTH = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: tx_byte[7:0], line_level[8], zero fill.
    input  logic [owbm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: action[1:0].
    input  logic [owbm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Master stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: line_drive[1:0], busy_res[2], done_res[3],
    // device_present[4], rx_byte[12:5], rejected[13], zero fill.
    output logic [owbm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [owbm_pkg::CFG_W-1:0]      i_cfg_data
);
    import owbm_pkg::*;

    t_cfg_bank  w_cfg;
    t_result    w_result;

    logic       r_in_valid;
    t_action    r_in_action;
    logic [7:0] r_in_tx;
    logic       r_in_level;

    logic       r_out_valid;
    t_result    r_out_result;

    logic       w_adv;
    logic       w_step;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= t_action'(s_axis_tuser[1:0]);
            r_in_tx     <= s_axis_tdata[7:0];
            r_in_level  <= s_axis_tdata[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_result <= w_result;
        end
    end

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    owbm_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_step),
        .i_action     (r_in_action),
        .i_tx_byte    (r_in_tx),
        .i_line_level (r_in_level),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, r_out_result};

endmodule

// ----- hw/rtl/owbm_cfg.sv -----
// Timing register bank written through the configuration port.
`timescale 1ns / 1ps

module owbm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [owbm_pkg::CFG_W-1:0]   i_cfg_data,
    output owbm_pkg::t_cfg_bank          o_cfg
);
    import owbm_pkg::*;

    t_cfg_bank r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET_VALUES;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_addr] <= i_cfg_data;
        end
    end

    assign o_cfg = r_regs;

endmodule

// ----- hw/rtl/owbm_core.sv -----
// Bus sequencer: phase state, tick timer and bit shifter, one tick per advance.
`timescale 1ns / 1ps

module owbm_core #(
    parameter int TIMER_WIDTH = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  owbm_pkg::t_action   i_action,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_line_level,
    input  owbm_pkg::t_cfg_bank i_cfg,
    output owbm_pkg::t_result   o_result
);
    import owbm_pkg::*;

    localparam int LW = ((TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W) + 1;
    localparam logic [LW-1:0] TIMER_CAP = LW'(1) << TIMER_WIDTH;

    t_phase                 r_phase, n_phase, s_phase;
    t_action                r_op, n_op, s_op;
    logic [TIMER_WIDTH-1:0] r_tc, n_tc, s_tc;
    logic [2:0]             r_bi, n_bi, s_bi;
    logic [7:0]             r_sd, n_sd, s_sd;
    logic                   r_pf, n_pf;

    logic       w_rej;
    t_drive     w_drive;
    logic       w_busy;
    logic       w_timed;
    logic [CFG_W-1:0] w_len;
    logic [LW-1:0]    w_len_ext, w_eff_len, w_tc_inc;
    logic       w_end;
    logic       w_done;
    logic       w_pres;
    logic [7:0] w_rx;

    // A command taken in idle turns this same tick into the first tick of the operation.
    always_comb begin
        s_phase = r_phase;
        s_op    = r_op;
        s_tc    = r_tc;
        s_bi    = r_bi;
        s_sd    = r_sd;
        w_rej   = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_action != ACT_NONE) begin
                s_op = i_action;
                s_tc = '0;
                s_bi = '0;
                s_sd = (i_action == ACT_WRITE) ? i_tx_byte : 8'd0;
                unique case (i_action)
                    ACT_RESET: s_phase = PH_RST_LOW;
                    ACT_WRITE: s_phase = i_tx_byte[0] ? PH_W1_LOW : PH_W0_LOW;
                    ACT_READ:  s_phase = PH_R_LOW;
                    default:   s_phase = r_phase;
                endcase
            end
        end else if (i_action != ACT_NONE) begin
            w_rej = 1'b1;
        end
    end

    // Per-phase outputs: line drive, busy flag and phase length.
    always_comb begin
        w_drive = DRV_REL;
        w_len   = CFG_W'(1);
        w_busy  = 1'b1;
        w_timed = 1'b1;
        unique case (s_phase)
            PH_RST_LOW:  begin w_drive = DRV_LOW;  w_len = i_cfg[CFG_RESET_LOW];     end
            PH_RST_WAIT: begin w_drive = DRV_REL;  w_len = i_cfg[CFG_PRESENCE_WAIT]; end
            PH_RST_TAIL: begin w_drive = DRV_REL;  w_len = i_cfg[CFG_RESET_TAIL];    end
            PH_W0_LOW:   begin w_drive = DRV_LOW;  w_len = i_cfg[CFG_ZERO_LOW];      end
            PH_W1_LOW:   begin w_drive = DRV_LOW;  w_len = i_cfg[CFG_ONE_LOW];       end
            PH_W1_HIGH:  begin w_drive = DRV_HIGH; w_len = i_cfg[CFG_ONE_HIGH];      end
            PH_W_REC:    begin w_drive = DRV_REL;  w_len = WRITE_RECOVERY_TICKS;     end
            PH_R_LOW:    begin w_drive = DRV_LOW;  w_len = CFG_W'(1);                end
            PH_R_WAIT:   begin w_drive = DRV_REL;  w_len = i_cfg[CFG_READ_SAMPLE];   end
            PH_R_TAIL:   begin w_drive = DRV_REL;  w_len = i_cfg[CFG_READ_TAIL];     end
            default: begin
                w_busy  = 1'b0;
                w_timed = 1'b0;
            end
        endcase
    end

    // A zero length counts as one tick; lengths beyond the timer range saturate.
    assign w_len_ext = LW'(w_len);
    assign w_eff_len = (w_len_ext == '0) ? LW'(1) :
                       ((w_len_ext > TIMER_CAP) ? TIMER_CAP : w_len_ext);
    assign w_tc_inc  = LW'(s_tc) + LW'(1);
    assign w_end     = (w_tc_inc >= w_eff_len);

    // Next state: samples, timer and phase transitions.
    always_comb begin
        n_phase = s_phase;
        n_op    = s_op;
        n_tc    = s_tc;
        n_bi    = s_bi;
        n_sd    = s_sd;
        n_pf    = r_pf;
        w_done  = 1'b0;
        w_pres  = 1'b0;
        w_rx    = 8'd0;

        if (s_phase == PH_RST_TAIL && s_tc == '0) begin
            n_pf = ~i_line_level;
        end
        if (s_phase == PH_R_TAIL && s_tc == '0) begin
            n_sd[s_bi] = i_line_level;
        end

        if (!w_timed) begin
            if (s_phase != PH_IDLE) begin
                n_tc = '0;
            end
            n_phase = PH_IDLE;
        end else if (w_end) begin
            n_tc = '0;
            unique case (s_phase)
                PH_RST_LOW:  n_phase = PH_RST_WAIT;
                PH_RST_WAIT: n_phase = PH_RST_TAIL;
                PH_RST_TAIL: w_done  = 1'b1;
                PH_W0_LOW:   n_phase = PH_W_REC;
                PH_W1_LOW:   n_phase = PH_W1_HIGH;
                PH_W1_HIGH:  n_phase = PH_W_REC;
                PH_R_LOW:    n_phase = PH_R_WAIT;
                PH_R_WAIT:   n_phase = PH_R_TAIL;
                PH_W_REC, PH_R_TAIL: begin
                    if (s_bi == 3'd7) begin
                        w_done = 1'b1;
                    end else begin
                        n_bi = s_bi + 3'd1;
                        if (s_op == ACT_WRITE) begin
                            n_phase = n_sd[n_bi] ? PH_W1_LOW : PH_W0_LOW;
                        end else begin
                            n_phase = PH_R_LOW;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
            if (w_done) begin
                w_pres  = (s_op == ACT_RESET) ? n_pf : 1'b0;
                w_rx    = (s_op == ACT_READ) ? n_sd : 8'd0;
                n_phase = PH_IDLE;
            end
        end else begin
            n_tc = s_tc + TIMER_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= ACT_NONE;
            r_tc    <= '0;
            r_bi    <= '0;
            r_sd    <= '0;
            r_pf    <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tc    <= n_tc;
            r_bi    <= n_bi;
            r_sd    <= n_sd;
            r_pf    <= n_pf;
        end
    end

    always_comb begin
        o_result.rejected       = w_rej;
        o_result.rx_byte        = w_rx;
        o_result.device_present = w_pres;
        o_result.done_res       = w_done;
        o_result.busy_res       = w_busy;
        o_result.line_drive     = w_drive;
    end

endmodule

// ----- hw/rtl/owbm_checker.sv -----
// Port-level checks for the one-wire bus master, bound to the top level.
`timescale 1ns / 1ps

module owbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction changed while stalled");

    // The done tick always belongs to an operation.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
        else $error("done without busy");

    // Presence and received byte are reported only on a done tick.
    a_result_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[4] || m_axis_tdata[12:5] != 8'd0)
        |-> m_axis_tdata[3])
        else $error("presence or read byte outside done");

    // When no operation runs the line is released.
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0)
        else $error("line driven while idle");

    // An accepted tick yields a result through both stream registers.
    a_tick_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);

// ----- tb/sv/one_wire_bus_master_tb.sv -----
// Testbench for the one-wire bus master: tick streams checked against a per-tick predictor.
`timescale 1ns / 1ps

import owbm_pkg::*;

class owbm_tick_scoreboard;
    localparam int WRITE_REC_TICKS = 2;
    localparam int MAX_PRINTED     = 200;

    logic [CFG_W-1:0] timing [NUM_CFG];
    t_phase           phase;
    t_action          op;
    logic [8:0]       tick_cnt;
    logic [2:0]       bit_idx;
    logic [7:0]       shreg;
    logic             presence;
    t_result          expected_q [$];
    int errors;
    int ticks;
    int results;
    int rejects;
    int resets_done;
    int writes_done;
    int reads_done;

    function new();
        timing[CFG_RESET_LOW]     = 9'd480;
        timing[CFG_PRESENCE_WAIT] = 9'd60;
        timing[CFG_RESET_TAIL]    = 9'd240;
        timing[CFG_ZERO_LOW]      = 9'd60;
        timing[CFG_ONE_LOW]       = 9'd2;
        timing[CFG_ONE_HIGH]      = 9'd58;
        timing[CFG_READ_SAMPLE]   = 9'd14;
        timing[CFG_READ_TAIL]     = 9'd46;
        phase    = PH_IDLE;
        op       = ACT_NONE;
        tick_cnt = '0;
        bit_idx  = '0;
        shreg    = '0;
        presence = 1'b0;
        errors = 0; ticks = 0; results = 0; rejects = 0;
        resets_done = 0; writes_done = 0; reads_done = 0;
    endfunction

    function bit is_idle();
        return phase == PH_IDLE;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function t_phase slot_for_bit();
        return shreg[bit_idx] ? PH_W1_LOW : PH_W0_LOW;
    endfunction

    // Advances the bus sequence by one accepted tick and queues what the
    // master stream must show for it.
    function void note_tick(t_action act, logic [7:0] tx, logic lvl);
        t_result r;
        int      len;
        logic    bit_end;
        r       = '0;
        len     = 1;
        bit_end = 1'b0;
        ticks++;
        if (phase == PH_IDLE) begin
            if (act != ACT_NONE) begin
                op       = act;
                tick_cnt = '0;
                bit_idx  = '0;
                shreg    = (act == ACT_WRITE) ? tx : 8'h00;
                case (act)
                    ACT_RESET: phase = PH_RST_LOW;
                    ACT_WRITE: phase = slot_for_bit();
                    default:   phase = PH_R_LOW;
                endcase
            end
        end else if (act != ACT_NONE) begin
            r.rejected = 1'b1;
            rejects++;
        end

        if (phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            case (phase)
                PH_RST_LOW: begin
                    r.line_drive = DRV_LOW;
                    len = timing[CFG_RESET_LOW];
                end
                PH_RST_WAIT: len = timing[CFG_PRESENCE_WAIT];
                PH_RST_TAIL: begin
                    len = timing[CFG_RESET_TAIL];
                    // A device answers by holding the line low.
                    if (tick_cnt == 0) presence = ~lvl;
                end
                PH_W0_LOW: begin
                    r.line_drive = DRV_LOW;
                    len = timing[CFG_ZERO_LOW];
                end
                PH_W1_LOW: begin
                    r.line_drive = DRV_LOW;
                    len = timing[CFG_ONE_LOW];
                end
                PH_W1_HIGH: begin
                    r.line_drive = DRV_HIGH;
                    len = timing[CFG_ONE_HIGH];
                end
                PH_W_REC: len = WRITE_REC_TICKS;
                PH_R_LOW: r.line_drive = DRV_LOW;
                PH_R_WAIT: len = timing[CFG_READ_SAMPLE];
                PH_R_TAIL: begin
                    len = timing[CFG_READ_TAIL];
                    if (tick_cnt == 0) shreg[bit_idx] = lvl;
                end
                default: begin
                    phase      = PH_IDLE;
                    tick_cnt   = '0;
                    r.busy_res = 1'b0;
                end
            endcase
        end

        if (phase != PH_IDLE) begin
            // A zero count still lasts one tick.
            if (int'(tick_cnt) + 1 >= ((len == 0) ? 1 : len)) begin
                tick_cnt = '0;
                case (phase)
                    PH_RST_LOW:  phase = PH_RST_WAIT;
                    PH_RST_WAIT: phase = PH_RST_TAIL;
                    PH_RST_TAIL: r.done_res = 1'b1;
                    PH_W0_LOW:   phase = PH_W_REC;
                    PH_W1_LOW:   phase = PH_W1_HIGH;
                    PH_W1_HIGH:  phase = PH_W_REC;
                    PH_R_LOW:    phase = PH_R_WAIT;
                    PH_R_WAIT:   phase = PH_R_TAIL;
                    default:     bit_end = 1'b1;
                endcase
                if (bit_end) begin
                    if (bit_idx == 3'd7) begin
                        r.done_res = 1'b1;
                    end else begin
                        bit_idx++;
                        phase = (op == ACT_WRITE) ? slot_for_bit() : PH_R_LOW;
                    end
                end
                if (r.done_res) begin
                    case (op)
                        ACT_RESET: begin
                            r.device_present = presence;
                            resets_done++;
                        end
                        ACT_WRITE: writes_done++;
                        default: begin
                            r.rx_byte = shreg;
                            reads_done++;
                        end
                    endcase
                    phase = PH_IDLE;
                end
            end else begin
                tick_cnt++;
            end
        end
        expected_q.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [15:0] want, logic [15:0] seen);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, seen);
    endtask

    task check(logic [M_TDATA_W-1:0] data);
        t_result got;
        t_result exp;
        got = t_result'(data[RESULT_W-1:0]);
        if (expected_q.size() == 0) begin
            flag_mismatch("result transaction with nothing expected", '0, data);
            return;
        end
        exp = expected_q.pop_front();
        results++;
        if (got.line_drive !== exp.line_drive)
            flag_mismatch("line_drive", exp.line_drive, got.line_drive);
        if (got.busy_res !== exp.busy_res)
            flag_mismatch("busy_res", exp.busy_res, got.busy_res);
        if (got.done_res !== exp.done_res)
            flag_mismatch("done_res", exp.done_res, got.done_res);
        if (got.device_present !== exp.device_present)
            flag_mismatch("device_present", exp.device_present, got.device_present);
        if (got.rx_byte !== exp.rx_byte)
            flag_mismatch("rx_byte", exp.rx_byte, got.rx_byte);
        if (got.rejected !== exp.rejected)
            flag_mismatch("rejected", exp.rejected, got.rejected);
    endtask
endclass

module one_wire_bus_master_tb;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int LVL_LOW      = 0;
    localparam int LVL_HIGH     = 1;
    localparam int LVL_RANDOM   = 2;
    localparam int BLOCK_LATENCY = 8;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    owbm_tick_scoreboard sb;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_reqs  = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int cfg_sets   = 0;

    one_wire_bus_master #(
        .TIMER_WIDTH(9)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_reqs != hold_taken) begin
            hold_taken    <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("one_wire_bus_master_tb: FAIL");
        $finish;
    end

    function automatic logic pick_level(int mode);
        if (mode == LVL_RANDOM) return 1'($urandom);
        return (mode == LVL_HIGH);
    endfunction

    function automatic void pick_timings(output logic [CFG_W-1:0] v [NUM_CFG],
                                         input int lo, input int hi);
        int i;
        for (i = 0; i < NUM_CFG; i++) v[i] = CFG_W'($urandom_range(hi, lo));
    endfunction

    // Offers one tick and returns once its transaction has been accepted;
    // tvalid stays high so the next tick can follow without a gap.
    task automatic send_tick(t_action act, logic [7:0] tx, logic lvl);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, lvl, tx};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(act, tx, lvl);
    endtask

    task automatic drain_ops(int lvl_mode);
        while (!sb.is_idle()) send_tick(ACT_NONE, 8'($urandom), pick_level(lvl_mode));
    endtask

    task automatic directed_op(t_action act, logic [7:0] tx, int lvl_mode);
        send_tick(act, tx, pick_level(lvl_mode));
        drain_ops(lvl_mode);
    endtask

    // Stops offering ticks until every queued result has come back.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic load_timings(logic [CFG_W-1:0] v [NUM_CFG]);
        int i;
        for (i = 0; i < NUM_CFG; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
            sb.timing[i] = v[i];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_sets++;
    endtask

    // Mostly commands from idle, now and then one into a running operation.
    task automatic random_ticks(int n);
        t_action act;
        int      k;
        for (k = 0; k < n; k++) begin
            if (sb.is_idle())
                act = ($urandom_range(99) < 40) ? t_action'($urandom_range(3, 1)) : ACT_NONE;
            else
                act = ($urandom_range(99) < 4) ? t_action'($urandom_range(3, 1)) : ACT_NONE;
            send_tick(act, 8'($urandom), 1'($urandom));
            if ($urandom_range(999) < 6) wait_results();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] v [NUM_CFG];
        int               p;
        int               i;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Shortest timings: every operation and both line levels.
        for (i = 0; i < NUM_CFG; i++) v[i] = 9'd1;
        load_timings(v);
        directed_op(ACT_RESET, 8'h00, LVL_LOW);
        directed_op(ACT_RESET, 8'hFF, LVL_HIGH);
        directed_op(ACT_WRITE, 8'h00, LVL_RANDOM);
        directed_op(ACT_WRITE, 8'hFF, LVL_RANDOM);
        directed_op(ACT_READ, 8'h00, LVL_LOW);
        directed_op(ACT_READ, 8'hFF, LVL_HIGH);
        directed_op(ACT_READ, 8'h3C, LVL_RANDOM);
        // Commands during a reset, one of them on its done tick, then one
        // right after it that must start.
        send_tick(ACT_RESET, 8'h00, 1'b0);
        send_tick(ACT_READ, 8'hFF, 1'b1);
        send_tick(ACT_WRITE, 8'hC3, 1'b0);
        send_tick(ACT_READ, 8'h00, 1'b1);
        send_tick(ACT_RESET, 8'h00, 1'b0);
        drain_ops(LVL_RANDOM);
        settle();

        // Zero counts act as single ticks, then random counts from zero to two.
        for (i = 0; i < NUM_CFG; i++) v[i] = '0;
        load_timings(v);
        directed_op(ACT_RESET, 8'h00, LVL_RANDOM);
        directed_op(ACT_WRITE, 8'h96, LVL_RANDOM);
        directed_op(ACT_READ, 8'h00, LVL_RANDOM);
        pick_timings(v, 0, 2);
        settle();
        load_timings(v);
        random_ticks(40);
        drain_ops(LVL_RANDOM);
        settle();

        // Random short timings under each idling pattern; the last phase adds
        // a long result-side hold-off so the input side backs up.
        for (p = 0; p < 5; p++) begin
            pick_timings(v, 1, (p == 2) ? 24 : 6);
            load_timings(v);
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                3: begin idle_pct = 22; stall_pct = 22; end
                default: begin
                    idle_pct = 0; stall_pct = 0;
                    hold_reqs++;
                end
            endcase
            random_ticks(70);
            drain_ops(LVL_RANDOM);
            settle();
        end

        $display("Covered %0d ticks and %0d results over %0d timing settings.",
                 sb.ticks, sb.results, cfg_sets);
        $display("Finished %0d resets, %0d writes, %0d reads; %0d commands rejected.",
                 sb.resets_done, sb.writes_done, sb.reads_done, sb.rejects);
        if (sb.errors == 0) begin
            $display("one_wire_bus_master_tb: PASS");
        end else begin
            $display("one_wire_bus_master_tb: FAIL");
        end
        $finish;
    end
endmodule
